### rtl/bffa_pkg.sv
// Shared types and constants of the bitmap first-fit allocator.
package bffa_pkg;

  localparam int FUNC_W   = 1;
  localparam int COUNT_W  = 11;
  localparam int START_W  = 10;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 11;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [COUNT_W-1:0] POOL_UNITS_RST = 11'd1024;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_ZERO    = 2'd2,
    STAT_RANGE   = 2'd3
  } status_t;

  // Datapath operating mode, set by the controller.
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_CLEAR,
    MODE_SCAN,
    MODE_MARK,
    MODE_FREE
  } mode_t;

  typedef struct packed {
    mode_t   mode;
    logic    load;    // latch request beat
    logic    init;    // set up address walk
    logic    result;  // load response register
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic func_free;
    logic fail_zero;
    logic fail_room;
    logic fail_range;
    logic hit;
    logic scan_end;
    logic mark_end;
    logic free_end;
    logic clr_end;
    logic out_busy;
  } stat_t;

endpackage

### rtl/bffa_if.sv
// Handshake channel interfaces: request, response and configuration.
interface bffa_req_if;
  logic                           valid;
  logic                           ready;
  logic [bffa_pkg::FUNC_W-1:0]    func;
  logic [bffa_pkg::COUNT_W-1:0]   unit_count;
  logic [bffa_pkg::START_W-1:0]   free_start;

  modport source (output valid, func, unit_count, free_start, input ready);
  modport sink (input valid, func, unit_count, free_start, output ready);
endinterface

interface bffa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bffa_pkg::STATUS_W-1:0]  status;
  logic [bffa_pkg::START_W-1:0]   run_start;
  logic [bffa_pkg::USED_W-1:0]    used_total;

  modport source (output valid, status, run_start, used_total, input ready);
  modport sink (input valid, status, run_start, used_total, output ready);
endinterface

interface bffa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bffa_pkg::COUNT_W-1:0]   pool_units;

  modport source (output valid, pool_units, input ready);
  modport sink (input valid, pool_units, output ready);
endinterface

### rtl/bffa_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module bffa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bffa_ctrl.sv
// Allocator controller: sequences clear, check, scan, mark, free and response.
module bffa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  bffa_pkg::stat_t st,
  input  logic            in_valid,
  output logic            in_ready,
  output bffa_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_RESP
  } state_t;

  state_t            state;
  bffa_pkg::status_t code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code  <= bffa_pkg::STAT_OK;
    end else begin
      case (state)
        S_CLEAR: begin
          if (st.clr_end) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (st.fail_zero) begin
            code  <= bffa_pkg::STAT_ZERO;
            state <= S_RESP;
          end else if (st.func_free) begin
            if (st.fail_range) begin
              code  <= bffa_pkg::STAT_RANGE;
              state <= S_RESP;
            end else begin
              state <= S_FREE;
            end
          end else begin
            if (st.fail_room) begin
              code  <= bffa_pkg::STAT_NO_ROOM;
              state <= S_RESP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (st.hit) begin
            state <= S_MARK;
          end else if (st.scan_end) begin
            code  <= bffa_pkg::STAT_NO_ROOM;
            state <= S_RESP;
          end
        end
        S_MARK: begin
          if (st.mark_end) begin
            code  <= bffa_pkg::STAT_OK;
            state <= S_RESP;
          end
        end
        S_FREE: begin
          if (st.free_end) begin
            code  <= bffa_pkg::STAT_OK;
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!st.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.mode   = bffa_pkg::MODE_IDLE;
    cmd.load   = 1'b0;
    cmd.init   = 1'b0;
    cmd.result = 1'b0;
    cmd.code   = code;
    case (state)
      S_CLEAR: cmd.mode = bffa_pkg::MODE_CLEAR;
      S_IDLE:  cmd.load = in_valid;
      S_CHECK: cmd.init = !st.fail_zero &&
                          (st.func_free ? !st.fail_range : !st.fail_room);
      S_SCAN:  cmd.mode = bffa_pkg::MODE_SCAN;
      S_MARK:  cmd.mode = bffa_pkg::MODE_MARK;
      S_FREE:  cmd.mode = bffa_pkg::MODE_FREE;
      S_RESP:  cmd.result = !st.out_busy;
      default: cmd.mode = bffa_pkg::MODE_IDLE;
    endcase
  end

endmodule

### rtl/bffa_dp.sv
// Allocator datapath: bitmap RAM, address walk, run counter, used count, response register.
module bffa_dp #(
  parameter int POOL_MAX = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bffa_pkg::cmd_t                 cmd,
  output bffa_pkg::stat_t                st,
  input  logic [bffa_pkg::FUNC_W-1:0]    func,
  input  logic [bffa_pkg::COUNT_W-1:0]   unit_count,
  input  logic [bffa_pkg::START_W-1:0]   free_start,
  input  logic                           cfg_we,
  input  logic [bffa_pkg::COUNT_W-1:0]   cfg_pool_units,
  input  logic                           rsp_ready,
  output logic                           rsp_valid,
  output logic [bffa_pkg::STATUS_W-1:0]  rsp_status,
  output logic [bffa_pkg::START_W-1:0]   rsp_run_start,
  output logic [bffa_pkg::USED_W-1:0]    rsp_used_total
);

  localparam int AW = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
  localparam int PW = $clog2(POOL_MAX + 1);
  localparam int CW = (PW > bffa_pkg::COUNT_W) ? PW : bffa_pkg::COUNT_W;
  localparam int SW = CW + 1;

  logic [bffa_pkg::COUNT_W-1:0] pool_units;
  logic [bffa_pkg::FUNC_W-1:0]  func_q;
  logic [bffa_pkg::COUNT_W-1:0] count_q;
  logic [bffa_pkg::START_W-1:0] start_q;
  logic [PW-1:0]                used_count;
  logic [AW-1:0]                addr;
  logic                         issue_on;
  logic                         rv;
  logic [AW-1:0]                ra;
  logic [CW-1:0]                run;
  logic [AW-1:0]                mark_hi;
  logic [AW-1:0]                res_start;

  logic [CW-1:0] pool_eff, used_w, free_units, count_w, run_inc;
  logic [SW-1:0] range_end;
  logic [AW-1:0] pool_last, free_last, last_addr, first;
  logic          reading, hit, rdata;
  logic          ram_we, ram_wd;
  logic [AW-1:0] ram_wa;

  assign pool_eff   = (CW'(pool_units) < CW'(POOL_MAX)) ? CW'(pool_units) : CW'(POOL_MAX);
  assign used_w     = CW'(used_count);
  assign free_units = (used_w < pool_eff) ? (pool_eff - used_w) : '0;
  assign count_w    = CW'(count_q);
  assign range_end  = SW'(start_q) + SW'(count_q);
  assign pool_last  = AW'(pool_eff - CW'(1));
  assign free_last  = AW'(range_end - SW'(1));
  assign last_addr  = (cmd.mode == bffa_pkg::MODE_FREE) ? free_last : pool_last;
  assign reading    = ((cmd.mode == bffa_pkg::MODE_SCAN) ||
                       (cmd.mode == bffa_pkg::MODE_FREE)) && issue_on;
  assign run_inc    = run + CW'(1);
  assign first      = AW'(CW'(ra) + CW'(1) - count_w);
  assign hit        = (cmd.mode == bffa_pkg::MODE_SCAN) && rv && !rdata &&
                      (run_inc == count_w);

  always_comb begin
    st.func_free  = (func_q == bffa_pkg::FUNC_FREE);
    st.fail_zero  = (count_q == '0);
    st.fail_room  = (count_w > free_units);
    st.fail_range = (range_end > SW'(pool_eff));
    st.hit        = hit;
    st.scan_end   = (cmd.mode == bffa_pkg::MODE_SCAN) && rv && (ra == pool_last) && !hit;
    st.mark_end   = (cmd.mode == bffa_pkg::MODE_MARK) && (addr == mark_hi);
    st.free_end   = (cmd.mode == bffa_pkg::MODE_FREE) && rv && (ra == free_last);
    st.clr_end    = (cmd.mode == bffa_pkg::MODE_CLEAR) && (addr == AW'(POOL_MAX - 1));
    st.out_busy   = rsp_valid && !rsp_ready;
  end

  // Write port: clear sweep, run marking, or clearing a used bit read back
  always_comb begin
    ram_we = 1'b0;
    ram_wa = addr;
    ram_wd = 1'b0;
    case (cmd.mode)
      bffa_pkg::MODE_CLEAR: ram_we = 1'b1;
      bffa_pkg::MODE_MARK: begin
        ram_we = 1'b1;
        ram_wd = 1'b1;
      end
      bffa_pkg::MODE_FREE: begin
        ram_we = rv && rdata;
        ram_wa = ra;
      end
      default: ram_we = 1'b0;
    endcase
  end

  bffa_ram #(
    .WIDTH (1),
    .DEPTH (POOL_MAX)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_units <= bffa_pkg::POOL_UNITS_RST;
      used_count <= '0;
      addr       <= '0;
      issue_on   <= 1'b0;
      rv         <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_units <= cfg_pool_units;
      end

      // no read is issued in the check cycle, so rv starts each walk low
      rv <= reading;
      if (cmd.init) begin
        addr     <= (func_q == bffa_pkg::FUNC_FREE) ? AW'(start_q) : '0;
        issue_on <= 1'b1;
      end else if (hit) begin
        addr <= first;
      end else if (reading) begin
        addr <= addr + AW'(1);
        if (addr == last_addr) begin
          issue_on <= 1'b0;
        end
      end else if ((cmd.mode == bffa_pkg::MODE_MARK) ||
                   (cmd.mode == bffa_pkg::MODE_CLEAR)) begin
        addr <= addr + AW'(1);
      end

      if (hit) begin
        used_count <= PW'(used_w + count_w);
      end else if ((cmd.mode == bffa_pkg::MODE_FREE) && rv && rdata &&
                   (used_count != '0)) begin
        used_count <= used_count - PW'(1);
      end

      if (cmd.result) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      count_q <= unit_count;
      start_q <= free_start;
    end
    ra <= addr;
    if (cmd.init) begin
      run <= '0;
    end else if ((cmd.mode == bffa_pkg::MODE_SCAN) && rv) begin
      run <= rdata ? '0 : run_inc;
    end
    if (hit) begin
      mark_hi   <= ra;
      res_start <= first;
    end
    if (cmd.result) begin
      rsp_status     <= cmd.code;
      rsp_run_start  <= ((cmd.code == bffa_pkg::STAT_OK) && (func_q == bffa_pkg::FUNC_ALLOC)) ?
                        bffa_pkg::START_W'(res_start) : '0;
      rsp_used_total <= bffa_pkg::USED_W'(used_count);
    end
  end

endmodule

### rtl/bitmap_first_fit_allocator.sv
// Bitmap first-fit allocator top level: controller, datapath and channel hookup.
// Sequence: a zero count or failed check goes straight to the response; allocate runs a
//   linear scan of the bitmap RAM, one unit per cycle, then marks the found run unit by unit;
//   free walks its range one unit per cycle through the RAM read port.
// Throughput: one request in flight; the bitmap RAM's single read port sets the pace.
// Reset: synchronous; a clearing pass zeroes the bitmap, requests wait.
module bitmap_first_fit_allocator #(
  parameter int POOL_MAX = 1024
) (
  input logic      clk,
  input logic      rst,
  bffa_req_if.sink   req,
  bffa_rsp_if.source rsp,
  bffa_cfg_if.sink   cfg
);

  // Control/status bundles between the FSM and the datapath
  bffa_pkg::cmd_t  cmd;
  bffa_pkg::stat_t st;
  logic            in_ready;

  // One request at a time: ready only while the controller is idle.
  // A finished response sits in the output register, so the next beat
  // can be taken while the sink still stalls.
  assign req.ready = in_ready;

  // Pool size register is always writable; the block does not check that it is idle.
  assign cfg.ready = 1'b1;

  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath holds the bitmap, the used count and the response register
  bffa_dp #(
    .POOL_MAX (POOL_MAX)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .func           (req.func),
    .unit_count     (req.unit_count),
    .free_start     (req.free_start),
    .cfg_we         (cfg.valid),
    .cfg_pool_units (cfg.pool_units),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_status     (rsp.status),
    .rsp_run_start  (rsp.run_start),
    .rsp_used_total (rsp.used_total)
  );

  // A new result never overwrites a beat the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result |-> !(rsp.valid && !rsp.ready))
    else $error("response overwritten while stalled");

  // Only one request is worked on at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request taken while busy");

  // Failed requests report run start zero; free requests do too, but only failures are checked here
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != bffa_pkg::STAT_OK)) |-> (rsp.run_start == '0))
    else $error("nonzero run start on failed request");

  // Used count never exceeds the built pool
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.used_total <= POOL_MAX))
    else $error("used count above pool size");

endmodule
